/* sv/fba_pkg.sv */
// Shared types, codes and helpers for the frame bitmap allocator.
// No dependencies; imported by the core, the checker and the bench.
package fba_pkg;

  // Fixed field widths
  localparam int ADDR_W  = 40;
  localparam int OUT_W   = 24;
  localparam int CNT_W   = 13;
  localparam int WORD_W  = 32;
  localparam int BIT_W   = 5;
  localparam int CMP_W   = 42;

  localparam logic [CNT_W-1:0] FRAME_COUNT_RESET = 13'd4096;

  // Request codes
  localparam logic [1:0] ACT_ALLOC     = 2'd0;
  localparam logic [1:0] ACT_FREE      = 2'd1;
  localparam logic [1:0] ACT_MARK_USED = 2'd2;
  localparam logic [1:0] ACT_MARK_FREE = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FREE  = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  // Find the lowest clear bit: {found, index}
  function automatic logic [BIT_W:0] find_zero(word_t v);
    logic [BIT_W:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!v[i]) r = {1'b1, BIT_W'(i)};
    end
    return r;
  endfunction

endpackage

/* sv/frame_bitmap_allocator_core.sv */
// First-fit frame allocator over a two-level bitmap held in RAM, built on fba_pkg and fba_mem.
// Top level: request sequencer, frame count register and clearing pass.
//
// The used map lives in a leaf RAM of 32-bit words (one bit per frame, 1 = used)
// and a summary RAM with one "word full" bit per leaf word. One request is served
// at a time. Free, mark used and mark free read both RAMs, modify and write back,
// then present the result; an out of range request presents it without reading
// the RAMs. Allocate scans the summary RAM one word per cycle from address zero,
// at most MAX_FRAMES/1024 words (only the first while any of the lowest 1024
// frames is free), then reads the chosen leaf word; when every summary word is
// full it presents its result without reading a leaf word. The result then waits
// in the output register until transferred, and the next input is taken in the
// idle cycle after that, so no input is taken while a result is pending. After
// reset a clearing pass writes zero to every leaf word, one per cycle, during
// which no input is taken; configuration writes are taken at any time.
// MAX_FRAMES and FRAME_BYTES must be powers of two.
module frame_bitmap_allocator_core
  import fba_pkg::*;
#(
  parameter int MAX_FRAMES  = 4096,
  parameter int FRAME_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        action,
  input  logic [ADDR_W-1:0] frame_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  allocated_address,
  output logic [1:0]        status
);

  localparam int FBS    = $clog2(FRAME_BYTES);
  localparam int IDX_W  = $clog2(MAX_FRAMES);
  localparam int WORDS  = MAX_FRAMES / WORD_W;
  localparam int LW     = IDX_W - BIT_W;
  localparam int SWORDS = (WORDS + WORD_W - 1) / WORD_W;
  localparam int SAW    = SWORDS > 1 ? $clog2(SWORDS) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_LEAF  = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]       st;
  logic [CNT_W-1:0] frame_count;
  logic [1:0]       act;
  logic [SAW-1:0]   saddr;
  logic [LW-1:0]    wsel;
  logic [BIT_W-1:0] wbit;
  logic [BIT_W-1:0] kbit;
  word_t            sword;
  logic [LW-1:0]    clr;
  logic [OUT_W-1:0] res_addr;
  logic [1:0]       res_status;

  logic             l_we, s_we;
  logic [LW-1:0]    l_waddr, l_raddr;
  logic [SAW-1:0]   s_waddr, s_raddr;
  word_t            l_wdata, s_wdata, l_rdata, s_rdata;

  // Effective frame count, capped at capacity
  logic [CMP_W-1:0] limit;
  always_comb begin
    if (CMP_W'(frame_count) > CMP_W'(MAX_FRAMES)) limit = CMP_W'(MAX_FRAMES);
    else limit = CMP_W'(frame_count);
  end

  // Decode the requested frame
  logic [CMP_W-1:0] req_idx_wide;
  logic [IDX_W-1:0] req_idx;
  logic [LW-1:0]    req_word;
  logic             req_in_range;
  assign req_idx_wide = CMP_W'(frame_address >> FBS);
  assign req_idx      = IDX_W'(frame_address >> FBS);
  assign req_word     = req_idx[IDX_W-1:BIT_W];
  assign req_in_range = req_idx_wide < limit;

  // Summary scan: padding words beyond the map read as full
  word_t            s_pad, s_eff;
  logic [BIT_W:0]   s_find;
  logic [LW-1:0]    s_word;
  logic             s_last;
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      s_pad[b] = ((CMP_W'(saddr) << BIT_W) | CMP_W'(b)) >= CMP_W'(WORDS);
    end
  end
  assign s_eff  = s_rdata | s_pad;
  assign s_find = find_zero(s_eff);
  assign s_word = LW'({saddr, s_find[BIT_W-1:0]});
  assign s_last = saddr == SAW'(SWORDS - 1);

  // Leaf word search and update
  logic [BIT_W:0]   l_find;
  logic [IDX_W-1:0] alloc_idx;
  logic             alloc_ok;
  word_t            alloc_word, mod_word;
  logic             old_bit;
  assign l_find     = find_zero(l_rdata);
  assign alloc_idx  = {wsel, l_find[BIT_W-1:0]};
  assign alloc_ok   = l_find[BIT_W] && (CMP_W'(alloc_idx) < limit);
  assign alloc_word = l_rdata | (word_t'(1) << l_find[BIT_W-1:0]);
  assign old_bit    = l_rdata[kbit];
  always_comb begin
    mod_word = l_rdata;
    if (act == ACT_MARK_USED) mod_word[kbit] = 1'b1;
    else mod_word[kbit] = 1'b0;
  end

  // Drive the RAM ports
  always_comb begin
    l_we    = 1'b0;
    l_waddr = wsel;
    l_wdata = '0;
    s_we    = 1'b0;
    s_waddr = saddr;
    s_wdata = '0;
    l_raddr = req_word;
    s_raddr = SAW'(req_word / WORD_W);
    case (st)
      S_CLEAR: begin
        l_we    = 1'b1;
        l_waddr = clr;
        s_we    = CMP_W'(clr) < CMP_W'(SWORDS);
        s_waddr = SAW'(clr);
      end
      S_IDLE: begin
        if (action == ACT_ALLOC) s_raddr = '0;
      end
      S_SCAN: begin
        s_raddr = saddr + SAW'(1);
        l_raddr = s_word;
      end
      S_LEAF: begin
        l_we          = alloc_ok;
        l_wdata       = alloc_word;
        s_we          = alloc_ok;
        s_wdata       = sword;
        s_wdata[wbit] = &alloc_word;
      end
      S_MOD: begin
        l_we          = 1'b1;
        l_wdata       = mod_word;
        s_we          = 1'b1;
        s_wdata       = s_rdata;
        s_wdata[wbit] = &mod_word;
      end
      default: begin
      end
    endcase
  end

  fba_mem #(.DEPTH(WORDS), .WIDTH(WORD_W)) u_leaf (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  fba_mem #(.DEPTH(SWORDS), .WIDTH(WORD_W)) u_summary (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
    end else if (cfg_valid) begin
      frame_count <= cfg_data;
    end
  end

  // Request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= S_CLEAR;
      clr <= '0;
    end else begin
      case (st)
        S_CLEAR: begin
          clr <= clr + LW'(1);
          if (clr == LW'(WORDS - 1)) st <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            act <= action;
            if (action == ACT_ALLOC) begin
              saddr <= '0;
              st    <= S_SCAN;
            end else if (!req_in_range) begin
              res_addr   <= '0;
              res_status <= ST_RANGE;
              st         <= S_DONE;
            end else begin
              saddr <= SAW'(req_word / WORD_W);
              wsel  <= req_word;
              wbit  <= BIT_W'(req_word % WORD_W);
              kbit  <= req_idx[BIT_W-1:0];
              st    <= S_MOD;
            end
          end
        end
        S_SCAN: begin
          if (&s_eff) begin
            if (s_last) begin
              res_addr   <= '0;
              res_status <= ST_FULL;
              st         <= S_DONE;
            end else begin
              saddr <= saddr + SAW'(1);
            end
          end else begin
            wsel  <= s_word;
            wbit  <= s_find[BIT_W-1:0];
            sword <= s_rdata;
            st    <= S_LEAF;
          end
        end
        S_LEAF: begin
          if (alloc_ok) begin
            res_addr   <= OUT_W'(CMP_W'(alloc_idx) << FBS);
            res_status <= ST_OK;
          end else begin
            res_addr   <= '0;
            res_status <= ST_FULL;
          end
          st <= S_DONE;
        end
        S_MOD: begin
          res_addr <= '0;
          if (act == ACT_FREE && !old_bit) res_status <= ST_FREE;
          else res_status <= ST_OK;
          st <= S_DONE;
        end
        S_DONE: begin
          if (out_ready) st <= S_IDLE;
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  // Handshake and result
  assign in_ready          = st == S_IDLE;
  assign out_valid         = st == S_DONE;
  assign allocated_address = res_addr;
  assign status            = res_status;

endmodule

/* sv/fba_mem.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing; used for the leaf map and the summary map.
module fba_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/fba_checker.sv */
// Port-level checks for the frame bitmap allocator, bound to the top level.
// Depends on fba_pkg and frame_bitmap_allocator_core.
module fba_checker
  import fba_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [OUT_W-1:0]  allocated_address,
  input logic [1:0]        status
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(allocated_address) && $stable(status))
    else $error("stalled result changed");

  // Take no request while a result is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid)
    else $error("request taken with result pending");

  // One result per request: a transfer is not followed by another at once
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("result repeated");

  // Results with a status other than ok carry address zero
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> allocated_address == '0)
    else $error("address on failed result");

endmodule

bind frame_bitmap_allocator_core fba_checker u_fba_checker (.*);

/* bench/testbench.sv */
// Self-checking bench for frame_bitmap_allocator_core: directed table, then random phases.
// Depends on fba_pkg and the core RTL; predicts results from its own copy of the map, or takes them from the table.
module testbench
  import fba_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FRAMES  = 4096;
  localparam int FRAME_BYTES = 4096;
  localparam int FRAME_SHIFT = 12;
  localparam int QUIET_LIMIT = 4000;
  localparam int NUM_PHASES  = 8;

  typedef struct packed {
    logic [OUT_W-1:0] addr;
    logic [1:0]       status;
  } alloc_result_t;

  typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_t;

  // A config row carries the new frame count in its address column
  typedef struct {
    row_kind_t         kind;
    logic [1:0]        act;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    logic [OUT_W-1:0]  want_addr;
    logic [1:0]        want_status;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        action = ACT_ALLOC;
  logic [ADDR_W-1:0] frame_address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [OUT_W-1:0]  allocated_address;
  logic [1:0]        status;

  // Predictor state
  logic [MAX_FRAMES-1:0] frame_used = '0;
  logic [CNT_W-1:0]      frame_count_q = FRAME_COUNT_RESET;
  alloc_result_t         pending_results[$];

  int errors = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int requests_sent = 0;
  int count_writes = 0;
  int status_seen[4] = '{0, 0, 0, 0};

  stim_row_t directed_rows[28] = '{
    '{ROW_REQUEST, ACT_ALLOC,     40'h0,             1'b1, 24'h000000, ST_OK},
    '{ROW_REQUEST, ACT_ALLOC,     40'h0,             1'b1, 24'h001000, ST_OK},
    '{ROW_REQUEST, ACT_FREE,      40'h00_0000_0FFF,  1'b1, 24'h000000, ST_OK},
    '{ROW_REQUEST, ACT_FREE,      40'h0,             1'b1, 24'h000000, ST_FREE},
    '{ROW_REQUEST, ACT_ALLOC,     40'h0,             1'b1, 24'h000000, ST_OK},
    '{ROW_REQUEST, ACT_MARK_USED, 40'h00_00FF_FABC,  1'b1, 24'h000000, ST_OK},
    '{ROW_REQUEST, ACT_MARK_USED, 40'h00_00FF_FABC,  1'b1, 24'h000000, ST_OK},
    '{ROW_REQUEST, ACT_ALLOC,     40'hFF_FFFF_FFFF,  1'b1, 24'h002000, ST_OK},
    '{ROW_REQUEST, ACT_MARK_FREE, 40'h00_00FF_F000,  1'b1, 24'h000000, ST_OK},
    '{ROW_REQUEST, ACT_MARK_FREE, 40'h00_00FF_FFFF,  1'b1, 24'h000000, ST_OK},
    '{ROW_REQUEST, ACT_FREE,      40'h00_00FF_F000,  1'b1, 24'h000000, ST_FREE},
    '{ROW_REQUEST, ACT_FREE,      40'h00_0100_0000,  1'b1, 24'h000000, ST_RANGE},
    '{ROW_REQUEST, ACT_FREE,      40'hFF_FFFF_FFFF,  1'b1, 24'h000000, ST_RANGE},
    '{ROW_REQUEST, ACT_MARK_USED, 40'hFF_FFFF_FFFF,  1'b1, 24'h000000, ST_RANGE},
    '{ROW_REQUEST, ACT_MARK_FREE, 40'h80_0000_0000,  1'b1, 24'h000000, ST_RANGE},
    '{ROW_CONFIG,  ACT_ALLOC,     40'd0,             1'b0, 24'h000000, ST_OK},
    '{ROW_REQUEST, ACT_ALLOC,     40'h0,             1'b1, 24'h000000, ST_FULL},
    '{ROW_REQUEST, ACT_FREE,      40'h0,             1'b1, 24'h000000, ST_RANGE},
    '{ROW_REQUEST, ACT_MARK_USED, 40'h0,             1'b1, 24'h000000, ST_RANGE},
    '{ROW_REQUEST, ACT_MARK_FREE, 40'h0,             1'b1, 24'h000000, ST_RANGE},
    '{ROW_CONFIG,  ACT_ALLOC,     40'd8191,          1'b0, 24'h000000, ST_OK},
    '{ROW_REQUEST, ACT_MARK_USED, 40'h00_00FF_F000,  1'b1, 24'h000000, ST_OK},
    '{ROW_REQUEST, ACT_FREE,      40'h00_0100_0000,  1'b1, 24'h000000, ST_RANGE},
    '{ROW_CONFIG,  ACT_ALLOC,     40'd3,             1'b0, 24'h000000, ST_OK},
    '{ROW_REQUEST, ACT_ALLOC,     40'h0,             1'b1, 24'h000000, ST_FULL},
    '{ROW_REQUEST, ACT_MARK_FREE, 40'h00_0000_1000,  1'b1, 24'h000000, ST_OK},
    '{ROW_CONFIG,  ACT_ALLOC,     40'd4096,          1'b0, 24'h000000, ST_OK},
    '{ROW_REQUEST, ACT_ALLOC,     40'h0,             1'b0, 24'h000000, ST_OK}
  };

  logic [CNT_W-1:0] phase_counts[NUM_PHASES] = '{
    13'd8, 13'd40, 13'd1, 13'd8191, 13'd100, 13'd0, 13'd4096, 13'd17
  };

  frame_bitmap_allocator_core #(
    .MAX_FRAMES  (MAX_FRAMES),
    .FRAME_BYTES (FRAME_BYTES)
  ) i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .action            (action),
    .frame_address     (frame_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .allocated_address (allocated_address),
    .status            (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Frames in range: a count above capacity acts as full capacity
  function automatic int unsigned frames_live();
    return (frame_count_q > MAX_FRAMES) ? MAX_FRAMES : int'(frame_count_q);
  endfunction

  // Apply one request to the shadow map and return the result it should give
  function automatic alloc_result_t serve_request(input logic [1:0] act,
                                                  input logic [ADDR_W-1:0] addr);
    alloc_result_t    r;
    int unsigned      live;
    int unsigned      i;
    bit               found;
    longint unsigned  idx;
    live = frames_live();
    idx = addr >> FRAME_SHIFT;
    r.addr = '0;
    r.status = ST_OK;
    found = 1'b0;
    if (act == ACT_ALLOC) begin
      r.status = ST_FULL;
      for (i = 0; i < live && !found; i++) begin
        if (!frame_used[i]) begin
          frame_used[i] = 1'b1;
          r.addr = OUT_W'(longint'(i) << FRAME_SHIFT);
          r.status = ST_OK;
          found = 1'b1;
        end
      end
    end else if (idx >= live) begin
      r.status = ST_RANGE;
    end else if (act == ACT_FREE) begin
      if (!frame_used[idx]) r.status = ST_FREE;
      else frame_used[idx] = 1'b0;
    end else if (act == ACT_MARK_USED) begin
      frame_used[idx] = 1'b1;
    end else begin
      frame_used[idx] = 1'b0;
    end
    return r;
  endfunction

  // Mostly a frame near the live range with random offset; sometimes any address
  function automatic logic [ADDR_W-1:0] pick_frame_address();
    logic [ADDR_W-1:0] a;
    a = ADDR_W'({$urandom, $urandom});
    if ($urandom_range(99) < 85)
      a = (ADDR_W'($urandom_range(frames_live() + 1)) << FRAME_SHIFT)
          | ADDR_W'($urandom_range(FRAME_BYTES - 1));
    return a;
  endfunction

  function automatic logic [1:0] pick_action();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) return ACT_ALLOC;
    if (roll < 65) return ACT_FREE;
    if (roll < 80) return ACT_MARK_USED;
    return ACT_MARK_FREE;
  endfunction

  // Present one request, hold it until the transfer, then queue its expected result
  task automatic send_request(input logic [1:0] act, input logic [ADDR_W-1:0] addr,
                             input bit typed, input alloc_result_t typed_result);
    alloc_result_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    action <= act;
    frame_address <= addr;
    do @(posedge clk); while (!in_ready);
    predicted = serve_request(act, addr);
    if (typed) predicted = typed_result;
    pending_results.push_back(predicted);
    status_seen[predicted.status]++;
    requests_sent++;
  endtask

  // Drop valid and hold until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_frame_count(input logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    frame_count_q = value;
    count_writes++;
  endtask

  // Result side: check each transfer against the oldest expectation, then pick ready
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result address %h status %0d",
                 $time, allocated_address, status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (allocated_address !== want.addr) begin
          $display("%0t: allocated_address mismatch: expected %h actual %h",
                   $time, want.addr, allocated_address);
          errors++;
        end
        if (status !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, status);
          errors++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: end the run when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int phase_items;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table: sender idles often, receiver stalls more
    send_idle_pct = 23;
    recv_stall_pct = 65;
    foreach (directed_rows[row]) begin
      if (directed_rows[row].kind == ROW_CONFIG) begin
        wait_drained();
        write_frame_count(CNT_W'(directed_rows[row].addr));
      end else begin
        send_request(directed_rows[row].act, directed_rows[row].addr,
                     directed_rows[row].typed,
                     '{directed_rows[row].want_addr, directed_rows[row].want_status});
      end
    end

    // Random phases, each under its own frame count
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      if (phase == 3) begin
        send_idle_pct = 65;
        recv_stall_pct = 23;
      end
      if (phase == 6) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_frame_count(phase_counts[phase]);
      phase_items = (phase_counts[phase] == 0) ? 15 : 55;
      for (int n = 0; n < phase_items; n++) begin
        // hold the sender mid-phase until the pipeline is empty
        if (phase == 1 && n == 20) wait_drained();
        send_request(pick_action(), pick_frame_address(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Ran %0d requests under %0d frame-count writes, with both idle patterns and none.",
             requests_sent, count_writes);
    $display("Statuses: %0d ok, %0d full, %0d out of range, %0d already free.",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_RANGE],
             status_seen[ST_FREE]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/fba_pkg.sv
sv/fba_mem.sv
sv/frame_bitmap_allocator_core.sv
sv/fba_checker.sv
bench/testbench.sv
